// ----- rtl/fml_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fml_pkg
// shared types and codes of the fifo mutex lock: transaction structs,
// operation, status and wake codes, controller states
// ----------------------------------------------------------------------------
package fml_pkg;

	// thread identifier width, fixed by the transaction format
	localparam int TidBits = 8;

	// operation codes
	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_DESTROY = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DEADLOCK  = 2'd1;
	localparam logic [1:0] ST_NOT_OWNER = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// wake codes
	localparam logic WAKE_ACQUIRED = 1'b0;
	localparam logic WAKE_REMOVED  = 1'b1;

	typedef struct packed {
		logic [1:0]         operation;
		logic [TidBits-1:0] thread_id;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               blocked;
		logic               woken_valid;
		logic [TidBits-1:0] woken_thread;
		logic               woken_code;
		logic               last;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN
	} state_t;

endpackage

// ----- rtl/fml_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fml_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fml_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/fifo_mutex_lock.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_lock
// hardware mutex with a first-in first-out queue of waiting threads
// ----------------------------------------------------------------------------
// usage:
//  - req channel (valid/ready) carries one request transaction: acquire,
//    release or destroy, with the requesting thread id
//  - rsp channel (valid/ready) carries result transactions; every request
//    yields one result, except destroy with waiters, which yields one result
//    per waiter in queue order; last marks the final result of a request
//  - acquire and release: the accept cycle issues the read of the queue head
//    from the wait ram; in S_EXEC the controller decides, updates the lock
//    and loads the output register
//  - destroy makes one ram read per waiter; with nobody waiting it decides
//    in S_EXEC alone, like acquire and release
//  - a result becomes visible the cycle after the deciding cycle and is held
//    in the output register; a new request may be accepted while it waits
//  - when the receiver stalls with a result still pending, the controller
//    holds in its deciding state until the output register frees up
//  - reset (arst_n low) frees the lock and empties the queue at once; the
//    wait ram itself is not cleared, since only written entries are read
// ----------------------------------------------------------------------------
module fifo_mutex_lock
	import fml_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IdxW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

	// controller and lock state
	state_t             state_q, state_d;
	logic [TidBits-1:0] owner_q, owner_d;
	logic               held_q, held_d;
	logic [IdxW-1:0]    head_q, head_d;
	logic [IdxW-1:0]    tail_q, tail_d;
	logic [CntW-1:0]    count_q, count_d;

	// latched request
	logic [1:0]         op_q;
	logic [TidBits-1:0] tid_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic load;

	// wait ram ports
	logic               wr_en;
	logic [TidBits-1:0] head_data;

	logic accept;
	logic slot_free;
	logic pop;
	logic clear;
	logic [IdxW-1:0] head_next;
	logic [IdxW-1:0] tail_next;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

	// the read address follows the next head, so the registered ram output
	// shows the current queue head whenever the controller decides
	fml_ram #(
		.WIDTH(TidBits),
		.DEPTH(QUEUE_DEPTH)
	) u_wait_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tail_q),
		.wdata(tid_q),
		.raddr(head_d),
		.rdata(head_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			owner_q     <= '0;
			held_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			owner_q <= owner_d;
			held_q  <= held_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			tid_q <= req.thread_id;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		owner_d = owner_q;
		held_d  = held_q;
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		rsp_d   = '0;
		load    = 1'b0;
		wr_en   = 1'b0;
		pop     = 1'b0;
		clear   = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					load       = 1'b1;
					rsp_d.last = 1'b1;
					state_d    = S_IDLE;
					case (op_q)
						OP_ACQUIRE: begin
							if (held_q && owner_q == tid_q) begin
								rsp_d.status = ST_DEADLOCK;
							end else if (!held_q) begin
								owner_d = tid_q;
								held_d  = 1'b1;
							end else if (count_q == FullCnt) begin
								rsp_d.status = ST_FULL;
							end else begin
								// enqueue the waiter at the tail
								wr_en         = 1'b1;
								tail_d        = tail_next;
								count_d       = count_q + 1'b1;
								rsp_d.blocked = 1'b1;
							end
						end
						OP_RELEASE: begin
							if (!held_q || owner_q != tid_q) begin
								rsp_d.status = ST_NOT_OWNER;
							end else if (count_q != '0) begin
								// hand the lock to the queue head
								pop                = 1'b1;
								owner_d            = head_data;
								rsp_d.woken_valid  = 1'b1;
								rsp_d.woken_thread = head_data;
								rsp_d.woken_code   = WAKE_ACQUIRED;
							end else begin
								owner_d = '0;
								held_d  = 1'b0;
							end
						end
						OP_DESTROY: begin
							if (count_q == '0) begin
								clear = 1'b1;
							end else begin
								pop                = 1'b1;
								rsp_d.woken_valid  = 1'b1;
								rsp_d.woken_thread = head_data;
								rsp_d.woken_code   = WAKE_REMOVED;
								rsp_d.last         = (count_q == CntW'(1));
								if (count_q == CntW'(1)) begin
									clear = 1'b1;
								end else begin
									state_d = S_DRAIN;
								end
							end
						end
						default: begin
							// unused code: plain result, no state change
						end
					endcase
				end
			end
			S_DRAIN: begin
				// one waiter per cycle while the output register is free, head data refreshed by the read above
				if (slot_free) begin
					load               = 1'b1;
					pop                = 1'b1;
					rsp_d.woken_valid  = 1'b1;
					rsp_d.woken_thread = head_data;
					rsp_d.woken_code   = WAKE_REMOVED;
					rsp_d.last         = (count_q == CntW'(1));
					if (count_q == CntW'(1)) begin
						clear   = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (pop) begin
			head_d  = head_next;
			count_d = count_q - 1'b1;
		end
		if (clear) begin
			owner_d = '0;
			held_d  = 1'b0;
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
		end
	end

endmodule
